// ===== hdl/tcie_pkg.sv =====
// shared types and constants for the tiny cpu instruction executor
// no dependencies; used by every file of the block

package tcie_pkg;

   localparam int PROGRAM_DEPTH_DEF = 128;
   localparam int DATA_DEPTH_DEF    = 16;
   localparam int REG_COUNT_DEF     = 8;
   localparam int WORD_W            = 32;
   localparam int NEXT_PC_W         = 7;
   localparam int SKIP_STRIDE       = 4;

   typedef enum logic [3:0] {
      OP_LOAD   = 4'd1,
      OP_ADD    = 4'd2,
      OP_STORE  = 4'd3,
      OP_SUB    = 4'd4,
      OP_INPUT  = 4'd5,
      OP_OUTPUT = 4'd6,
      OP_HALT   = 4'd7,
      OP_JUMP   = 4'd8,
      OP_SKIPZ  = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [2:0]         dest_reg;
      logic [2:0]         src_reg;
      logic [3:0]         third_operand;
      logic signed [31:0] in_value;
   } req_type;

   typedef struct packed {
      logic [6:0]         next_pc;
      logic signed [31:0] out_value;
      logic               out_valid;
      logic               in_used;
      logic               halted;
   } rsp_type;

endpackage

// ===== hdl/tcie_ram.sv =====
// generic single write, single read ram with registered read data
// read returns the old word when read and write hit the same address
// depends on tcie_pkg for default sizes

module tcie_ram
   import tcie_pkg::*;
#(
   parameter int WIDTH = WORD_W,
   parameter int DEPTH = DATA_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tiny_cpu_instruction_executor_top.sv =====
// tiny cpu instruction executor: one instruction per transfer, one result per instruction
// the instruction is held in the input register; the result register loads when it fires
// throughput: one instruction per cycle if not stalled; regfile and data memory are read when
//   an instruction enters the input register, with a one-entry bypass for the write just made
// reset: synchronous; clears counter, halt flag, pipeline valids and per-entry valid bits,
//   so register and memory words read as zero until written; no clearing pass

module tiny_cpu_instruction_executor_top
   import tcie_pkg::*;
#(
   parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
   parameter int DATA_DEPTH    = DATA_DEPTH_DEF,
   parameter int REG_COUNT     = REG_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PC_W    = $clog2(PROGRAM_DEPTH);
   localparam int DATA_AW = $clog2(DATA_DEPTH);
   localparam int REG_AW  = $clog2(REG_COUNT);

   logic              in_valid_ff;
   req_type           in_data_ff;
   logic              fire;
   logic              load_in;

   logic [4:0]        third_ext;
   logic [REG_AW-1:0] ra_addr_in;
   logic [REG_AW-1:0] rb_addr_in;
   logic [DATA_AW-1:0] dm_raddr_in;
   logic [REG_AW-1:0] ra_addr_ff;
   logic [REG_AW-1:0] rb_addr_ff;
   logic [DATA_AW-1:0] dm_raddr_ff;
   logic              ra_vld_ff;
   logic              rb_vld_ff;
   logic              dm_vld_ff;

   logic [REG_COUNT-1:0]  rf_vld_ff;
   logic [DATA_DEPTH-1:0] dm_vld_bits_ff;

   logic [WORD_W-1:0] ra_rd;
   logic [WORD_W-1:0] rb_rd;
   logic [WORD_W-1:0] dm_rd;
   logic [WORD_W-1:0] ra_val;
   logic [WORD_W-1:0] rb_val;
   logic [WORD_W-1:0] dm_val;

   logic              rf_byp_vld_ff;
   logic [REG_AW-1:0] rf_byp_addr_ff;
   logic [WORD_W-1:0] rf_byp_data_ff;
   logic              dm_byp_vld_ff;
   logic [DATA_AW-1:0] dm_byp_addr_ff;
   logic [WORD_W-1:0] dm_byp_data_ff;

   logic              rf_we;
   logic [REG_AW-1:0] rf_waddr;
   logic [WORD_W-1:0] rf_wdata;
   logic              dm_we;
   logic [DATA_AW-1:0] dm_waddr;
   logic [WORD_W-1:0] dm_wdata;

   logic [PC_W-1:0]   pc_ff;
   logic [PC_W-1:0]   pc_in;
   logic [PC_W:0]     pc_sum;
   logic              halt_ff;
   logic              halt_in;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   // handshake
   assign fire      = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~fire;
   assign load_in   = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read addresses from the incoming instruction
   assign third_ext   = {1'b0, req_data.third_operand};
   assign rb_addr_in  = (third_ext >= 5'(REG_COUNT)) ? REG_AW'(third_ext - 5'(REG_COUNT))
                                                     : REG_AW'(third_ext);
   assign ra_addr_in  = (req_data.opcode == OP_ADD || req_data.opcode == OP_SUB)
                        ? REG_AW'(req_data.src_reg) : REG_AW'(req_data.dest_reg);
   assign dm_raddr_in = DATA_AW'(req_data.third_operand);

   tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (load_in),
      .rd_addr (ra_addr_in),
      .rd_data (ra_rd)
   );

   tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (load_in),
      .rd_addr (rb_addr_in),
      .rd_data (rb_rd)
   );

   tcie_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_dm (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (load_in),
      .rd_addr (dm_raddr_in),
      .rd_data (dm_rd)
   );

   // operands: bypass of the write made on the load edge, else ram word, else zero
   assign ra_val = (rf_byp_vld_ff && rf_byp_addr_ff == ra_addr_ff) ? rf_byp_data_ff :
                   (ra_vld_ff ? ra_rd : '0);
   assign rb_val = (rf_byp_vld_ff && rf_byp_addr_ff == rb_addr_ff) ? rf_byp_data_ff :
                   (rb_vld_ff ? rb_rd : '0);
   assign dm_val = (dm_byp_vld_ff && dm_byp_addr_ff == dm_raddr_ff) ? dm_byp_data_ff :
                   (dm_vld_ff ? dm_rd : '0);

   // execute
   always_comb begin
      rf_we       = 1'b0;
      rf_waddr    = REG_AW'(in_data_ff.dest_reg);
      rf_wdata    = ra_val;
      dm_we       = 1'b0;
      dm_waddr    = DATA_AW'(in_data_ff.third_operand);
      dm_wdata    = ra_val;
      pc_sum      = {1'b0, pc_ff};
      halt_in     = halt_ff;
      rsp_data_in = '0;
      if (!halt_ff) begin
         case (in_data_ff.opcode)
            OP_LOAD: begin
               rf_we    = fire;
               rf_wdata = dm_val;
               pc_sum   = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_ADD: begin
               rf_we    = fire;
               rf_wdata = ra_val + rb_val;
               pc_sum   = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_STORE: begin
               dm_we  = fire;
               pc_sum = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_SUB: begin
               rf_we    = fire;
               rf_wdata = ra_val - rb_val;
               pc_sum   = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_INPUT: begin
               rf_we               = fire;
               rf_wdata            = in_data_ff.in_value;
               rsp_data_in.in_used = 1'b1;
               pc_sum              = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_OUTPUT: begin
               rsp_data_in.out_value = ra_val;
               rsp_data_in.out_valid = 1'b1;
               pc_sum                = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_HALT: begin
               halt_in = 1'b1;
               pc_sum  = {1'b0, pc_ff} + (PC_W+1)'(1);
            end
            OP_JUMP: begin
               pc_sum = (PC_W+1)'(in_data_ff.third_operand);
            end
            OP_SKIPZ: begin
               pc_sum = {1'b0, pc_ff} + ((ra_val == '0) ? (PC_W+1)'(SKIP_STRIDE)
                                                        : (PC_W+1)'(1));
            end
            default: begin
            end
         endcase
      end
      pc_in = (pc_sum >= (PC_W+1)'(PROGRAM_DEPTH)) ? PC_W'(pc_sum - (PC_W+1)'(PROGRAM_DEPTH))
                                                   : PC_W'(pc_sum);
      rsp_data_in.next_pc = NEXT_PC_W'(pc_in);
      rsp_data_in.halted  = halt_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pc_ff          <= '0;
         halt_ff        <= 1'b0;
         rf_vld_ff      <= '0;
         dm_vld_bits_ff <= '0;
         rf_byp_vld_ff  <= 1'b0;
         dm_byp_vld_ff  <= 1'b0;
      end else begin
         if (load_in) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= pc_in;
            halt_ff      <= halt_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rf_we) begin
            rf_vld_ff[rf_waddr] <= 1'b1;
         end
         if (dm_we) begin
            dm_vld_bits_ff[dm_waddr] <= 1'b1;
         end
         if (load_in) begin
            rf_byp_vld_ff <= rf_we;
            dm_byp_vld_ff <= dm_we;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_data_ff     <= req_data;
         ra_addr_ff     <= ra_addr_in;
         rb_addr_ff     <= rb_addr_in;
         dm_raddr_ff    <= dm_raddr_in;
         ra_vld_ff      <= rf_vld_ff[ra_addr_in];
         rb_vld_ff      <= rf_vld_ff[rb_addr_in];
         dm_vld_ff      <= dm_vld_bits_ff[dm_raddr_in];
         rf_byp_addr_ff <= rf_waddr;
         rf_byp_data_ff <= rf_wdata;
         dm_byp_addr_ff <= dm_waddr;
         dm_byp_data_ff <= dm_wdata;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hdl/tcie_checker.sv =====
// port-level assertions for tiny_cpu_instruction_executor_top
// depends on tcie_pkg; bound to the top level at the end of this file

module tcie_checker
   import tcie_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic       seen_halt_ff;
   logic [6:0] halt_pc_ff;
   logic       rsp_xfer;

   assign rsp_xfer = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_xfer && rsp_data.halted && !seen_halt_ff) begin
         seen_halt_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer && rsp_data.halted && !seen_halt_ff) begin
         halt_pc_ff <= rsp_data.next_pc;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_halt_ff |-> rsp_data.halted && rsp_data.next_pc == halt_pc_ff &&
                                    !rsp_data.out_valid && !rsp_data.in_used)
      else $error("result after halt is not the held state");

   a_out_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_value == '0)
      else $error("out_value nonzero without out_valid");

   a_one_io: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.out_valid && rsp_data.in_used))
      else $error("output and input in one transfer");

   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request dropped while stalled");

endmodule

bind tiny_cpu_instruction_executor_top tcie_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
